>>> rtl/lpos_pkg.sv
package lpos_pkg;

    localparam int unsigned GAIN_W  = 13;
    localparam int unsigned CRUSH_W = 4;
    localparam int unsigned LEVEL_W = 9;

    localparam logic [GAIN_W-1:0]  GAIN_MIN  = 13'd256;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 13'd4096;
    localparam logic [CRUSH_W-1:0] CRUSH_MIN = 4'd1;
    localparam logic [CRUSH_W-1:0] CRUSH_MAX = 4'd8;
    localparam logic [7:0]         MID_CODE  = 8'h7F;
    localparam logic [7:0]         FULL_CODE = 8'hFF;
    localparam logic [7:0]         ZERO_CODE = 8'h00;
    localparam logic [7:0]         DIV_CODE  = 8'hFF;

    typedef enum logic [1:0] {
        WAVE_SINE  = 2'd0,
        WAVE_TRI   = 2'd1,
        WAVE_PULSE = 2'd2,
        WAVE_RAMP  = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        REG_WAVE   = 3'd0,
        REG_GAIN   = 3'd1,
        REG_MASK   = 3'd2,
        REG_THRESH = 3'd3,
        REG_FOLD   = 3'd4,
        REG_CRUSH  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        wave_t               wave;
        logic [GAIN_W-1:0]   gain;
        logic [7:0]          mask;
        logic [7:0]          thresh;
        logic                fold;
        logic [CRUSH_W-1:0]  bits;
    } cfg_t;

    localparam logic [7:0] SINE_ROM [256] = '{
        8'h7F, 8'h82, 8'h85, 8'h88, 8'h8B, 8'h8F, 8'h92, 8'h95,
        8'h98, 8'h9B, 8'h9E, 8'hA1, 8'hA4, 8'hA7, 8'hAA, 8'hAD,
        8'hB0, 8'hB3, 8'hB6, 8'hB8, 8'hBB, 8'hBE, 8'hC1, 8'hC3,
        8'hC6, 8'hC8, 8'hCB, 8'hCD, 8'hD0, 8'hD2, 8'hD5, 8'hD7,
        8'hD9, 8'hDB, 8'hDD, 8'hE0, 8'hE2, 8'hE4, 8'hE5, 8'hE7,
        8'hE9, 8'hEB, 8'hEC, 8'hEE, 8'hEF, 8'hF1, 8'hF2, 8'hF4,
        8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFB,
        8'hFC, 8'hFD, 8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE,
        8'hFF, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFD, 8'hFD,
        8'hFC, 8'hFB, 8'hFB, 8'hFA, 8'hF9, 8'hF8, 8'hF7, 8'hF6,
        8'hF5, 8'hF4, 8'hF2, 8'hF1, 8'hEF, 8'hEE, 8'hEC, 8'hEB,
        8'hE9, 8'hE7, 8'hE5, 8'hE4, 8'hE2, 8'hE0, 8'hDD, 8'hDB,
        8'hD9, 8'hD7, 8'hD5, 8'hD2, 8'hD0, 8'hCD, 8'hCB, 8'hC8,
        8'hC6, 8'hC3, 8'hC1, 8'hBE, 8'hBB, 8'hB8, 8'hB6, 8'hB3,
        8'hB0, 8'hAD, 8'hAA, 8'hA7, 8'hA4, 8'hA1, 8'h9E, 8'h9B,
        8'h98, 8'h95, 8'h92, 8'h8F, 8'h8B, 8'h88, 8'h85, 8'h82,
        8'h7F, 8'h7C, 8'h79, 8'h76, 8'h73, 8'h6F, 8'h6C, 8'h69,
        8'h66, 8'h63, 8'h60, 8'h5D, 8'h5A, 8'h57, 8'h54, 8'h51,
        8'h4E, 8'h4B, 8'h48, 8'h46, 8'h43, 8'h40, 8'h3D, 8'h3B,
        8'h38, 8'h36, 8'h33, 8'h31, 8'h2E, 8'h2C, 8'h29, 8'h27,
        8'h25, 8'h23, 8'h21, 8'h1E, 8'h1C, 8'h1A, 8'h19, 8'h17,
        8'h15, 8'h13, 8'h12, 8'h10, 8'h0F, 8'h0D, 8'h0C, 8'h0A,
        8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03,
        8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
        8'h02, 8'h03, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h12, 8'h13,
        8'h15, 8'h17, 8'h19, 8'h1A, 8'h1C, 8'h1E, 8'h21, 8'h23,
        8'h25, 8'h27, 8'h29, 8'h2C, 8'h2E, 8'h31, 8'h33, 8'h36,
        8'h38, 8'h3B, 8'h3D, 8'h40, 8'h43, 8'h46, 8'h48, 8'h4B,
        8'h4E, 8'h51, 8'h54, 8'h57, 8'h5A, 8'h5D, 8'h60, 8'h63,
        8'h66, 8'h69, 8'h6C, 8'h6F, 8'h73, 8'h76, 8'h79, 8'h7C
    };

endpackage

>>> rtl/lpos_if.sv
interface lpos_step_if;
    logic               valid;
    logic               ready;
    logic [31:0]        phase_step;
    logic signed [31:0] fm_offset;

    modport source (output valid, output phase_step, output fm_offset, input ready);
    modport sink   (input valid, input phase_step, input fm_offset, output ready);
endinterface

interface lpos_level_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

>>> rtl/lofi_phase_oscillator_shaper_top.sv
// Single-voice 8-bit lo-fi oscillator with a sine, triangle-fold, pulse or ramp shaper.
// step_chan carries one request per audio tick: a phase step and a signed FM offset.
// level_chan returns one signed 9-bit level per request, in request order.
// Both channels move a request at a clock edge where valid and ready are high.
// A request passes through the s1, s2, s3, s4, s5 and output registers before its result
// reaches level_chan. A new request is taken every cycle while results drain, unless
// level_chan stalls with a result waiting, so throughput is one per cycle. The phase
// accumulator lives in a one-entry memory with a registered read; the value written back
// is forwarded to the next request, so the read-add-write loop does not limit the rate.
// When the receiver holds level_chan.ready low with a result waiting, the whole
// pipeline freezes and step_chan.ready drops in the same cycle; nothing is lost.
// Reset clears the phase to zero, empties the pipeline and loads the registers with
// sine, gain 1.0, mask 0, threshold 127, masked fold and 8-bit output. step_chan.ready
// stays low until live_reg is set by a clock edge after reset is released; no request
// is taken before that.
// The APB port writes and reads the six shaper registers; write them only while no
// request is in flight.
module lofi_phase_oscillator_shaper_top #(
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    lpos_step_if.sink           step_chan,
    lpos_level_if.source        level_chan,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned PROD_W = PHASE_BITS + lpos_pkg::GAIN_W;

    logic                        live_reg;
    logic [1:0]                  wave_reg;
    logic [lpos_pkg::GAIN_W-1:0] gain_reg;
    logic [7:0]                  mask_reg;
    logic [7:0]                  thresh_reg;
    logic                        fold_reg;
    logic [lpos_pkg::CRUSH_W-1:0] crush_reg;

    logic                        s1_v_reg;
    logic [PHASE_BITS-1:0]       s1_step_reg;
    logic [PHASE_BITS-1:0]       s1_fm_reg;
    logic                        s2_v_reg;
    logic [7:0]                  s2_upper_reg;

    logic [PHASE_BITS-1:0]       phase_mem [1];
    logic [PHASE_BITS-1:0]       phase_rd_reg;
    logic                        written_reg;
    logic                        fwd_v_reg;
    logic [PHASE_BITS-1:0]       fwd_reg;

    lpos_pkg::cfg_t              cfg;
    lpos_pkg::reg_idx_t          reg_idx;
    logic                        cfg_write;
    logic                        en;
    logic                        accept;
    logic                        wr;
    logic [PHASE_BITS-1:0]       phase_cur;
    logic [PHASE_BITS-1:0]       phase_next;
    logic [PROD_W-1:0]           pulse_prod;
    logic [7:0]                  s2_upper_next;
    logic                        level_valid;
    logic signed [8:0]           level;

    assign reg_idx   = lpos_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg   <= lpos_pkg::WAVE_SINE;
            gain_reg   <= lpos_pkg::GAIN_MIN;
            mask_reg   <= 8'd0;
            thresh_reg <= lpos_pkg::MID_CODE;
            fold_reg   <= 1'b0;
            crush_reg  <= lpos_pkg::CRUSH_MAX;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                lpos_pkg::REG_WAVE:   wave_reg   <= pwdata[1:0];
                lpos_pkg::REG_GAIN:   gain_reg   <= pwdata[lpos_pkg::GAIN_W-1:0];
                lpos_pkg::REG_MASK:   mask_reg   <= pwdata[7:0];
                lpos_pkg::REG_THRESH: thresh_reg <= pwdata[7:0];
                lpos_pkg::REG_FOLD:   fold_reg   <= pwdata[0];
                lpos_pkg::REG_CRUSH:  crush_reg  <= pwdata[lpos_pkg::CRUSH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lpos_pkg::REG_WAVE:   prdata = 32'(wave_reg);
            lpos_pkg::REG_GAIN:   prdata = 32'(gain_reg);
            lpos_pkg::REG_MASK:   prdata = 32'(mask_reg);
            lpos_pkg::REG_THRESH: prdata = 32'(thresh_reg);
            lpos_pkg::REG_FOLD:   prdata = 32'(fold_reg);
            lpos_pkg::REG_CRUSH:  prdata = 32'(crush_reg);
            default:              prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.wave   = lpos_pkg::wave_t'(wave_reg);
        cfg.mask   = mask_reg;
        cfg.thresh = thresh_reg;
        cfg.fold   = fold_reg;
        if (gain_reg < lpos_pkg::GAIN_MIN)
        begin
            cfg.gain = lpos_pkg::GAIN_MIN;
        end
        else if (gain_reg > lpos_pkg::GAIN_MAX)
        begin
            cfg.gain = lpos_pkg::GAIN_MAX;
        end
        else
        begin
            cfg.gain = gain_reg;
        end
        if (crush_reg < lpos_pkg::CRUSH_MIN)
        begin
            cfg.bits = lpos_pkg::CRUSH_MIN;
        end
        else if (crush_reg > lpos_pkg::CRUSH_MAX)
        begin
            cfg.bits = lpos_pkg::CRUSH_MAX;
        end
        else
        begin
            cfg.bits = crush_reg;
        end
    end

    assign en              = !level_valid || level_chan.ready;
    assign step_chan.ready = live_reg && en;
    assign accept          = step_chan.valid && step_chan.ready;
    assign wr              = en && s1_v_reg;

    always_comb
    begin
        if (fwd_v_reg)
        begin
            phase_cur = fwd_reg;
        end
        else if (written_reg)
        begin
            phase_cur = phase_rd_reg;
        end
        else
        begin
            phase_cur = '0;
        end
        phase_next = phase_cur + s1_fm_reg + s1_step_reg;
        pulse_prod = PROD_W'(phase_cur) * PROD_W'(cfg.gain);
        if (cfg.wave == lpos_pkg::WAVE_PULSE)
        begin
            s2_upper_next = pulse_prod[PHASE_BITS+7:PHASE_BITS];
        end
        else
        begin
            s2_upper_next = phase_cur[PHASE_BITS-1:PHASE_BITS-8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            phase_mem[0] <= phase_next;
        end
        phase_rd_reg <= phase_mem[0];
        fwd_reg      <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= 1'b0;
            written_reg <= 1'b0;
            fwd_v_reg   <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
        end
        else
        begin
            live_reg    <= 1'b1;
            written_reg <= written_reg || wr;
            fwd_v_reg   <= wr;
            if (en)
            begin
                s1_v_reg <= accept;
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_step_reg <= step_chan.phase_step[PHASE_BITS-1:0];
            s1_fm_reg   <= step_chan.fm_offset[PHASE_BITS-1:0];
        end
        if (en)
        begin
            s2_upper_reg <= s2_upper_next;
        end
    end

    lpos_shaper u_shaper (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .upper_valid (s2_v_reg),
        .upper       (s2_upper_reg),
        .cfg         (cfg),
        .level_valid (level_valid),
        .level       (level)
    );

    assign level_chan.valid = level_valid;
    assign level_chan.level = level;

endmodule

>>> rtl/lpos_shaper.sv
module lpos_shaper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                upper_valid,
    input  logic [7:0]          upper,
    input  lpos_pkg::cfg_t      cfg,
    output logic                level_valid,
    output logic signed [8:0]   level
);

    logic        s3_v_reg;
    logic        s4_v_reg;
    logic        s5_v_reg;
    logic        out_v_reg;
    logic [7:0]  s3_byte_reg;
    logic [7:0]  s4_byte_reg;
    logic [7:0]  s5_byte_reg;
    logic signed [8:0] level_reg;

    logic [7:0]  masked;
    logic [7:0]  fold_src;
    logic [7:0]  s3_byte_next;
    logic [20:0] gain_prod;
    logic [7:0]  s4_byte_next;
    logic [7:0]  offset_byte;
    logic [7:0]  s5_byte_next;
    logic signed [8:0] diff;
    logic [7:0]  mag;
    logic [15:0] scaled;
    logic [23:0] recip;
    logic [7:0]  q0;
    logic [16:0] rem;
    logic [7:0]  quot;
    logic signed [8:0] level_next;

    always_comb
    begin
        masked   = upper ^ cfg.mask;
        fold_src = cfg.fold ? upper : masked;
        case (cfg.wave)
            lpos_pkg::WAVE_PULSE:
            begin
                s3_byte_next = (masked > cfg.thresh) ? lpos_pkg::FULL_CODE
                                                     : lpos_pkg::ZERO_CODE;
            end
            lpos_pkg::WAVE_TRI:
            begin
                s3_byte_next = (upper > cfg.thresh) ? ~fold_src : masked;
            end
            default:
            begin
                s3_byte_next = masked;
            end
        endcase
    end

    always_comb
    begin
        gain_prod = 21'(s3_byte_reg) * 21'(cfg.gain);
        if (cfg.wave == lpos_pkg::WAVE_PULSE)
        begin
            s4_byte_next = s3_byte_reg;
        end
        else
        begin
            s4_byte_next = gain_prod[15:8];
        end
    end

    always_comb
    begin
        if (s4_byte_reg > cfg.thresh)
        begin
            offset_byte = 8'(s4_byte_reg + lpos_pkg::MID_CODE - cfg.thresh);
        end
        else
        begin
            offset_byte = s4_byte_reg;
        end
        if (cfg.wave == lpos_pkg::WAVE_SINE)
        begin
            s5_byte_next = lpos_pkg::SINE_ROM[~offset_byte];
        end
        else
        begin
            s5_byte_next = s4_byte_reg;
        end
    end

    // Division by 255 uses the reciprocal 257/65536, which is low by at most one.
    always_comb
    begin
        diff   = $signed({1'b0, s5_byte_reg}) - $signed({1'b0, lpos_pkg::MID_CODE});
        mag    = diff[8] ? 8'(-diff) : diff[7:0];
        scaled = 16'(mag) << cfg.bits;
        recip  = {scaled, 8'b0} + 24'(scaled);
        q0     = recip[23:16];
        rem    = 17'(scaled) - 17'({q0, 8'b0}) + 17'(q0);
        quot   = q0 + 8'(rem >= 17'(lpos_pkg::DIV_CODE));
        level_next = diff[8] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg  <= upper_valid;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            out_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_byte_reg <= s3_byte_next;
            s4_byte_reg <= s4_byte_next;
            s5_byte_reg <= s5_byte_next;
            level_reg   <= level_next;
        end
    end

    assign level_valid = out_v_reg;
    assign level       = level_reg;

endmodule

>>> rtl/lpos_checker.sv
module lpos_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [8:0] level
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level))
        else $error("Level changed or vanished while stalled.");

    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_ready)
        else $error("Channels not idle when reset is released.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level >= -9'sd128) && (level <= 9'sd128))
        else $error("Level outside the crushed range.");

endmodule

bind lofi_phase_oscillator_shaper_top lpos_checker u_lpos_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (step_chan.ready),
    .out_valid (level_chan.valid),
    .out_ready (level_chan.ready),
    .level     (level_chan.level)
);
